// ----- hw/rtl/box_filter_replicate_border_defines.svh -----
// assertion macros shared by the box filter rtl
`ifndef BOX_FILTER_REPLICATE_BORDER_DEFINES_SVH
`define BOX_FILTER_REPLICATE_BORDER_DEFINES_SVH
`ifndef SYNTHESIS
`define BFR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("box filter check failed");
`define BFR_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("box filter forbidden condition");
`else
`define BFR_ASSERT(lbl, prop)
`define BFR_NEVER(lbl, cond)
`endif
`endif

// ----- hw/rtl/bfr_pkg.sv -----
// shared constants, types and helpers of the box filter
`timescale 1ns / 1ps
`default_nettype none
package bfr_pkg;
	localparam int MAX_WIDTH       = 1024;
	localparam int MAX_HALF_WINDOW = 3;
	localparam int ROW_LIMIT       = 1024;
	localparam int STORE_ROWS      = 2 * MAX_HALF_WINDOW + 1;
	localparam int COL_W           = $clog2(MAX_WIDTH);
	localparam int ROW_W           = $clog2(ROW_LIMIT);
	localparam int SLOT_W          = $clog2(STORE_ROWS);
	localparam int SIZE_W          = 11;
	localparam int SUM_W           = 14;
	localparam int QUO_W           = 8;
	localparam int DIV_CELLS       = QUO_W;
	localparam int STEP_CAP        = 4;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HALF_WINDOW  = 2'd2;
	localparam logic [1:0] REG_COLOR_MODE   = 2'd3;

	typedef struct packed {
		logic                        run_end;
		logic                        frame_end;
		logic [SUM_W-1:0]            divs;
		logic [2:0][SUM_W-1:0]       rem;
		logic [2:0][QUO_W-1:0]       quo;
	} cell_word_t;

	// window area (2k+1)^2
	function automatic logic [5:0] win_area(input logic [1:0] k);
		logic [5:0] a;
		case (k)
			2'd0: a = 6'd1;
			2'd1: a = 6'd9;
			2'd2: a = 6'd25;
			default: a = 6'd49;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/bfr_div_cell.sv -----
// one restoring-division cell: yields one quotient bit per channel
`timescale 1ns / 1ps
`default_nettype none
module bfr_div_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire bfr_pkg::cell_word_t in_word,
	output logic                    out_vld,
	output bfr_pkg::cell_word_t     out_word
);
	import bfr_pkg::*;

	logic       vld_q;
	cell_word_t word_q;
	cell_word_t nxt;

	always_comb begin
		nxt = in_word;
		nxt.divs = in_word.divs >> 1;
		for (int ch = 0; ch < 3; ch++) begin
			if (in_word.rem[ch] >= in_word.divs) begin
				nxt.rem[ch] = in_word.rem[ch] - in_word.divs;
				nxt.quo[ch] = {in_word.quo[ch][QUO_W-2:0], 1'b1};
			end else begin
				nxt.quo[ch] = {in_word.quo[ch][QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign out_vld  = vld_q;
	assign out_word = word_q;
endmodule
`default_nettype wire

// ----- hw/rtl/box_filter_replicate_border.sv -----
// a window is summed from the line store, divided in the divider cells and registered
// at the output; window sums run one at a time on the single line store read port
// a word with no result due is accepted, then checked; the next word
// waits until all results it caused have entered the divider chain
// reset clears control and counters; line store contents stay undefined
`timescale 1ns / 1ps
`default_nettype none
`include "box_filter_replicate_border_defines.svh"
module box_filter_replicate_border (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // chan0, chan1, chan2
	input  wire logic        s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // mean0, mean1, mean2
	output logic             m_tlast,  // run_end
	output logic             m_tuser,  // frame_end
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [10:0] cfg_data
);
	import bfr_pkg::*;

	typedef enum logic [2:0] {IDLE, CHECK, SUM, WAIT, FIN} state_t;

	state_t state_q;

	logic [SIZE_W-1:0] frame_width_q, frame_height_q;
	logic [1:0]        half_window_q;
	logic              color_mode_q;

	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic              done_q;
	logic [2:0]        budget_q;
	logic              have_pend_q;
	logic              frame_end_pend_q;
	logic signed [3:0] dx_q, dy_q;
	logic [2:0][SUM_W-1:0] acc_q;

	logic [23:0] store [STORE_ROWS*MAX_WIDTH];
	logic [23:0] rd_data_s1;
	logic        rd_vld_s1;

	// effective sizes
	logic [SIZE_W-1:0] w_eff, h_eff, wm1, hm1;
	always_comb begin
		if (frame_width_q == '0) w_eff = SIZE_W'(1);
		else if (frame_width_q > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
		else w_eff = frame_width_q;
		if (frame_height_q == '0) h_eff = SIZE_W'(1);
		else if (frame_height_q > SIZE_W'(ROW_LIMIT)) h_eff = SIZE_W'(ROW_LIMIT);
		else h_eff = frame_height_q;
		wm1 = w_eff - SIZE_W'(1);
		hm1 = h_eff - SIZE_W'(1);
	end

	// readiness of the next output position
	logic [SIZE_W-1:0] rr, cc;
	logic              ready, more;
	always_comb begin
		rr = SIZE_W'(out_row_q) + SIZE_W'(half_window_q);
		cc = SIZE_W'(out_col_q) + SIZE_W'(half_window_q);
		if (rr > hm1) rr = hm1;
		if (cc > wm1) cc = wm1;
		ready = done_q || (rr < SIZE_W'(in_row_q)) ||
			(rr == SIZE_W'(in_row_q) && cc < SIZE_W'(in_col_q));
		more = (budget_q != 3'd0) && ready;
	end

	// window read address with border replication
	logic signed [12:0] r_s, c_s, delta;
	logic signed [4:0]  slot_s;
	logic [SLOT_W-1:0]  rd_slot;
	logic [COL_W-1:0]   rd_col;
	always_comb begin
		r_s = $signed({3'b0, out_row_q}) + 13'(dy_q);
		c_s = $signed({3'b0, out_col_q}) + 13'(dx_q);
		if (r_s < 0) r_s = '0;
		if (r_s > $signed({2'b0, hm1})) r_s = $signed({2'b0, hm1});
		if (c_s < 0) c_s = '0;
		if (c_s > $signed({2'b0, wm1})) c_s = $signed({2'b0, wm1});
		delta  = r_s - $signed({3'b0, out_row_q});
		slot_s = $signed({2'b0, out_slot_q}) + delta[4:0];
		if (slot_s < 0) slot_s = slot_s + 5'sd7;
		else if (slot_s >= 5'sd7) slot_s = slot_s - 5'sd7;
		rd_slot = slot_s[SLOT_W-1:0];
		rd_col  = c_s[COL_W-1:0];
	end

	logic signed [3:0] kpos, kneg;
	assign kpos = $signed({2'b0, half_window_q});
	assign kneg = -kpos;

	logic accept, is_pixel, en, push;
	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_pixel = !s_tuser;
	assign en       = !m_tvalid || m_tready;
	assign push     = (state_q == CHECK) && have_pend_q && en;

	// write position, restarted after a completed frame
	logic [ROW_W-1:0]  wr_row;
	logic [COL_W-1:0]  wr_col;
	logic [SLOT_W-1:0] wr_slot;
	assign wr_row  = done_q ? '0 : in_row_q;
	assign wr_col  = done_q ? '0 : in_col_q;
	assign wr_slot = done_q ? '0 : in_slot_q;

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			store[{wr_slot, wr_col}] <= s_tdata;
		end
		rd_data_s1 <= store[{rd_slot, rd_col}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= IDLE;
			frame_width_q    <= SIZE_W'(512);
			frame_height_q   <= SIZE_W'(512);
			half_window_q    <= 2'd1;
			color_mode_q     <= 1'b1;
			in_row_q         <= '0;
			in_col_q         <= '0;
			in_slot_q        <= '0;
			out_row_q        <= '0;
			out_col_q        <= '0;
			out_slot_q       <= '0;
			done_q           <= 1'b0;
			budget_q         <= '0;
			have_pend_q      <= 1'b0;
			frame_end_pend_q <= 1'b0;
			dx_q             <= '0;
			dy_q             <= '0;
			acc_q            <= '0;
			rd_vld_s1        <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == SUM);
			if (rd_vld_s1) begin
				acc_q[0] <= acc_q[0] + SUM_W'(rd_data_s1[7:0]);
				acc_q[1] <= acc_q[1] + SUM_W'(rd_data_s1[15:8]);
				acc_q[2] <= acc_q[2] + SUM_W'(rd_data_s1[23:16]);
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					REG_HALF_WINDOW:  half_window_q  <= cfg_data[1:0];
					REG_COLOR_MODE:   color_mode_q   <= cfg_data[0];
					default: ;
				endcase
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_slot_q  <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_slot_q <= '0;
				done_q     <= 1'b0;
			end else begin
				unique case (state_q)
					IDLE: begin
						if (accept) begin
							state_q     <= CHECK;
							have_pend_q <= 1'b0;
							if (is_pixel) begin
								budget_q <= 3'(STEP_CAP);
								if (done_q) begin
									out_row_q  <= '0;
									out_col_q  <= '0;
									out_slot_q <= '0;
								end
								done_q <= (SIZE_W'(wr_col) == wm1) &&
									(SIZE_W'(wr_row) == hm1);
								if (SIZE_W'(wr_col) == wm1) begin
									in_col_q <= '0;
									if (SIZE_W'(wr_row) == hm1) begin
										in_row_q  <= '0;
										in_slot_q <= '0;
									end else begin
										in_row_q  <= wr_row + ROW_W'(1);
										in_slot_q <= (wr_slot == SLOT_W'(STORE_ROWS - 1)) ?
											'0 : wr_slot + SLOT_W'(1);
									end
								end else begin
									in_row_q  <= wr_row;
									in_slot_q <= wr_slot;
									in_col_q  <= wr_col + COL_W'(1);
								end
							end else begin
								budget_q <= 3'd1;
							end
						end
					end
					CHECK: begin
						if (!have_pend_q || en) begin
							have_pend_q <= 1'b0;
							if (more) begin
								state_q <= SUM;
								acc_q   <= '0;
								dx_q    <= kneg;
								dy_q    <= kneg;
							end else begin
								state_q <= IDLE;
							end
						end
					end
					SUM: begin
						if (dx_q == kpos) begin
							dx_q <= kneg;
							dy_q <= dy_q + 4'sd1;
							if (dy_q == kpos) state_q <= WAIT;
						end else begin
							dx_q <= dx_q + 4'sd1;
						end
					end
					WAIT: begin
						state_q <= FIN;
					end
					FIN: begin
						state_q     <= CHECK;
						have_pend_q <= 1'b1;
						budget_q    <= budget_q - 3'd1;
						if (SIZE_W'(out_row_q) == hm1 && SIZE_W'(out_col_q) == wm1) begin
							frame_end_pend_q <= 1'b1;
							in_row_q   <= '0;
							in_col_q   <= '0;
							in_slot_q  <= '0;
							out_row_q  <= '0;
							out_col_q  <= '0;
							out_slot_q <= '0;
							done_q     <= 1'b0;
						end else begin
							frame_end_pend_q <= 1'b0;
							if (SIZE_W'(out_col_q) == wm1) begin
								out_col_q  <= '0;
								out_row_q  <= out_row_q + ROW_W'(1);
								out_slot_q <= (out_slot_q == SLOT_W'(STORE_ROWS - 1)) ?
									'0 : out_slot_q + SLOT_W'(1);
							end else begin
								out_col_q <= out_col_q + COL_W'(1);
							end
						end
					end
					default: state_q <= IDLE;
				endcase
			end
		end
	end

	// divider chain head
	cell_word_t head;
	always_comb begin
		head.run_end   = !more;
		head.frame_end = frame_end_pend_q;
		head.divs      = SUM_W'(win_area(half_window_q)) << (QUO_W - 1);
		head.rem       = acc_q;
		head.quo       = '0;
	end

	logic       vld_c  [DIV_CELLS+1];
	cell_word_t word_c [DIV_CELLS+1];
	assign vld_c[0]  = push;
	assign word_c[0] = head;

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		bfr_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld_c[i]),
			.in_word  (word_c[i]),
			.out_vld  (vld_c[i+1]),
			.out_word (word_c[i+1])
		);
	end

	logic out_vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_c[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata[7:0]   <= word_c[DIV_CELLS].quo[0];
			m_tdata[15:8]  <= color_mode_q ? word_c[DIV_CELLS].quo[1] : '0;
			m_tdata[23:16] <= color_mode_q ? word_c[DIV_CELLS].quo[2] : '0;
			m_tlast        <= word_c[DIV_CELLS].run_end;
			m_tuser        <= word_c[DIV_CELLS].frame_end;
		end
	end
	assign m_tvalid = out_vld_q;

	`BFR_ASSERT(a_rd_from_sum, rd_vld_s1 |-> $past(state_q == SUM))
	`BFR_NEVER(a_budget_cap, budget_q > 3'(STEP_CAP))
	`BFR_NEVER(a_slot_range, in_slot_q >= SLOT_W'(STORE_ROWS) || out_slot_q >= SLOT_W'(STORE_ROWS))
	`BFR_ASSERT(a_fin_pends, state_q == FIN |=> have_pend_q && state_q == CHECK)
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the streaming box filter with replicated borders
`timescale 1ns / 1ps
module tb;
	import bfr_pkg::*;

	typedef struct packed {
		logic [23:0] means;     // mean0, mean1, mean2 from the lowest bit up
		logic        run_end;
		logic        frame_end;
	} mean_word_t;

	localparam bit ACT_PIXEL = 1'b0;
	localparam bit ACT_DRAIN = 1'b1;

	class box_mean_board;
		logic [23:0] pix_mem [0:STORE_ROWS*MAX_WIDTH-1];
		int unsigned wid, hgt, rad, colr;
		int unsigned in_r, in_c, out_r, out_c;
		bit done;
		mean_word_t due_q[$];
		int errs;

		function new();
			wid = 512; hgt = 512; rad = 1; colr = 1;
			errs = 0;
			restart();
		endfunction

		function void restart();
			in_r = 0; in_c = 0; out_r = 0; out_c = 0; done = 0;
		endfunction

		function int unsigned eff_w();
			return (wid < 1) ? 1 : (wid > MAX_WIDTH) ? MAX_WIDTH : wid;
		endfunction

		function int unsigned eff_h();
			return (hgt < 1) ? 1 : (hgt > ROW_LIMIT) ? ROW_LIMIT : hgt;
		endfunction

		function int unsigned eff_k();
			return (rad > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : rad;
		endfunction

		function void write_reg(logic [1:0] idx, logic [10:0] val);
			case (idx)
				REG_FRAME_WIDTH:  wid = val;
				REG_FRAME_HEIGHT: hgt = val;
				REG_HALF_WINDOW:  rad = val[1:0];
				REG_COLOR_MODE:   colr = val[0];
			endcase
			restart();
		endfunction

		function bit window_ready();
			int unsigned rr, cc;
			rr = out_r + eff_k();
			cc = out_c + eff_k();
			if (rr > eff_h() - 1) rr = eff_h() - 1;
			if (cc > eff_w() - 1) cc = eff_w() - 1;
			if (done) return 1;
			if (rr < in_r) return 1;
			return (rr == in_r) && (cc < in_c);
		endfunction

		function void emit_mean();
			int k, r, c, area;
			int sum [3];
			logic [23:0] px;
			mean_word_t m;
			k = eff_k();
			area = (2 * k + 1) * (2 * k + 1);
			sum = '{0, 0, 0};
			for (int dy = -k; dy <= k; dy++) begin
				r = int'(out_r) + dy;
				if (r < 0) r = 0;
				if (r > int'(eff_h()) - 1) r = eff_h() - 1;
				for (int dx = -k; dx <= k; dx++) begin
					c = int'(out_c) + dx;
					if (c < 0) c = 0;
					if (c > int'(eff_w()) - 1) c = eff_w() - 1;
					px = pix_mem[(r % STORE_ROWS) * MAX_WIDTH + c];
					for (int ch = 0; ch < 3; ch++) sum[ch] += px[8*ch +: 8];
				end
			end
			m.means[7:0]   = sum[0] / area;
			m.means[15:8]  = colr ? 8'(sum[1] / area) : 8'd0;
			m.means[23:16] = colr ? 8'(sum[2] / area) : 8'd0;
			m.run_end = 0;
			m.frame_end = (out_r == eff_h() - 1) && (out_c == eff_w() - 1);
			due_q.push_back(m);
			if (m.frame_end) begin
				restart();
			end else begin
				out_c++;
				if (out_c >= eff_w()) begin
					out_c = 0;
					out_r++;
				end
			end
		endfunction

		function void note(bit act, logic [23:0] d);
			int cnt;
			cnt = 0;
			if (act == ACT_PIXEL) begin
				if (done) restart();
				pix_mem[(in_r % STORE_ROWS) * MAX_WIDTH + in_c] = d;
				in_c++;
				if (in_c >= eff_w()) begin
					in_c = 0;
					in_r++;
					if (in_r >= eff_h()) begin
						in_r = 0;
						done = 1;
					end
				end
				while (cnt < STEP_CAP && window_ready()) begin
					emit_mean();
					cnt++;
				end
			end else if (window_ready()) begin
				emit_mean();
				cnt = 1;
			end
			if (cnt > 0) due_q[$].run_end = 1;
		endfunction

		function void check(logic [23:0] d, logic last, logic fe);
			mean_word_t want;
			if (due_q.size() == 0) begin
				errs++;
				if (errs <= 10) $display("unexpected word: means %h last %b fe %b", d, last, fe);
				return;
			end
			want = due_q.pop_front();
			if (want.means[7:0] !== d[7:0] || want.means[15:8] !== d[15:8] ||
					want.means[23:16] !== d[23:16] || want.run_end !== last ||
					want.frame_end !== fe) begin
				errs++;
				if (errs <= 10)
					$display("mismatch: expected means %h last %b fe %b, got %h %b %b",
						want.means, want.run_end, want.frame_end, d, last, fe);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [10:0] cfg_data;

	box_mean_board board;
	bit            calm;
	int            pix_sent;
	int            stall_left;

	box_filter_replicate_border i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial clk = 0;
	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("[box_filter_replicate_border] ERROR");
		$finish;
	end

	// receiver with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			m_tready <= 0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check(m_tdata, m_tlast, m_tuser);
	end

	task automatic push_word(bit act, logic [23:0] d);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= act;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		board.note(act, d);
		if (act == ACT_PIXEL) pix_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (board.due_q.size() != 0) @(posedge clk);
		// a drain with nothing due may still be in flight
		repeat (200) @(posedge clk);
	endtask

	task automatic set_regs(int w, int h, int k, int cm);
		logic [10:0] vals [4];
		vals = '{11'(w), 11'(h), 11'(k), 11'(cm)};
		settle();
		for (int i = 0; i < 4; i++) begin
			cfg_we   <= 1;
			cfg_addr <= 2'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			board.write_reg(2'(i), vals[i]);
		end
		cfg_we <= 0;
	endtask

	task automatic flush_ready();
		while (board.window_ready()) push_word(ACT_DRAIN, 24'($urandom));
	endtask

	// frame of random pixels with occasional drain noise, then flush what is due
	task automatic run_frame(int w, int h, int k, int cm, int npix);
		set_regs(w, h, k, cm);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(0, 9) == 0) push_word(ACT_DRAIN, 24'($urandom));
			push_word(ACT_PIXEL, 24'($urandom));
		end
		flush_ready();
	endtask

	initial begin
		int w, h;
		board = new();
		calm = 0;
		pix_sent = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		cfg_we = 0;
		cfg_addr = REG_FRAME_WIDTH;
		cfg_data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// small colour frame with extreme pixel values, drain before anything is due
		set_regs(3, 2, 1, 1);
		push_word(ACT_DRAIN, 24'hffffff);
		push_word(ACT_PIXEL, 24'h000000);
		push_word(ACT_PIXEL, 24'hffffff);
		push_word(ACT_PIXEL, 24'h00ff00);
		push_word(ACT_PIXEL, 24'hff00ff);
		push_word(ACT_PIXEL, 24'hffffff);
		push_word(ACT_PIXEL, 24'h000000);
		flush_ready();
		push_word(ACT_DRAIN, 24'h0);

		// zero sizes saturate to a single pixel frame, gray mode
		set_regs(0, 0, 0, 0);
		push_word(ACT_PIXEL, 24'hffffff);
		push_word(ACT_PIXEL, 24'h123456);

		// full frame with results still due, then a new pixel drops them
		set_regs(6, 2, 3, 1);
		for (int i = 0; i < 12; i++) push_word(ACT_PIXEL, 24'($urandom));
		push_word(ACT_PIXEL, 24'hffffff);
		push_word(ACT_PIXEL, 24'h000000);
		flush_ready();

		// oversize registers saturate to the largest frame sides
		run_frame(2047, 1, 3, 1, 12);
		run_frame(1, 2047, 3, 0, 10);
		run_frame(1024, 1024, 2, 1, 3);

		while (pix_sent < 80) begin
			if (pix_sent > 65) calm = 1;
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 5);
			run_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 1),
				($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h) : w * h);
		end

		calm = 1;
		settle();
		if (board.errs == 0)
			$display("[box_filter_replicate_border] OK");
		else
			$display("[box_filter_replicate_border] ERROR");
		$finish;
	end
endmodule
